### design/flux_pll_bit_decoder_defines.svh
// Assertion macros for the flux PLL bit decoder.
// Included by the top level only; no other dependencies.
`ifndef FLUX_PLL_BIT_DECODER_DEFINES_SVH
`define FLUX_PLL_BIT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPBD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/fpbd_pkg.sv
// Package for the flux PLL bit decoder: field widths, register indexes,
// reset values and the sequencer state type. No dependencies.
`default_nettype none

package fpbd_pkg;

  localparam int INTERVAL_W = 16;
  localparam int CELL_W     = 20;
  localparam int GAIN_W     = 12;
  localparam int LIMIT_W    = 16;
  localparam int PHASE_W    = 24;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CELL_W-1:0]  CELL_RESET  = 20'd12288;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd410;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd65535;

  localparam logic signed [PHASE_W:0] PHASE_MAX = 25'sd8388607;
  localparam logic signed [PHASE_W:0] PHASE_MIN = -25'sd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL  = 2'd0,
    REG_GAIN  = 2'd1,
    REG_LIMIT = 2'd2
  } fpbd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ERR,
    ST_MUL,
    ST_UPD,
    ST_BITS
  } fpbd_state_t;

endpackage

`default_nettype wire

### design/fpbd_flux_if.sv
// Input channel of the flux PLL bit decoder: one flux interval word.
// Depends on fpbd_pkg.
`default_nettype none

interface fpbd_flux_if;
  import fpbd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] flux_interval;
  logic                  track_start;

  modport source (output valid, flux_interval, track_start, input ready);
  modport sink   (input valid, flux_interval, track_start, output ready);
endinterface

`default_nettype wire

### design/fpbd_byte_if.sv
// Output channel of the flux PLL bit decoder: one decoded byte word.
// Depends on fpbd_pkg.
`default_nettype none

interface fpbd_byte_if;
  import fpbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [INDEX_W-1:0] byte_index;

  modport source (output valid, out_byte, byte_index, input ready);
  modport sink   (input valid, out_byte, byte_index, output ready);
endinterface

`default_nettype wire

### design/flux_pll_bit_decoder.sv
// Flux interval decoder with a digital PLL: rounds intervals to bit cells,
// tracks phase, and packs bits into bytes.
// Depends on fpbd_pkg, fpbd_flux_if, fpbd_byte_if and the defines header.
// Usage:
//   flux_in  : valid/ready channel, one word per flux interval (sample count)
//              plus a track_start flag that clears phase, partial byte and
//              byte count before the interval is used.
//   byte_out : valid/ready channel, one word per completed byte with its index.
//   cfg_*    : write port for cell length (Q.8), PLL gain (Q12) and byte
//              limit; write only while the decoder is idle.
// Timing: flux_in.ready is high only in idle. An accepted interval runs
//   through one shared add/compare unit for three rounding compares, then
//   the error, multiply and phase update states, then one bit step per bit
//   cell (1 to 4); the next interval is taken only after the last bit step.
//   A byte appears in the output register in the cycle after its last bit.
//   Intervals past the byte limit are accepted in idle and produce nothing.
// Reset (rst, synchronous) restores the default registers and clears phase,
//   partial byte, bit and byte counters and the output valid flag.
// Stall: a finished byte waits in the output register while the next interval
//   is accepted; the bit stage holds only when a new byte meets a full register.
`default_nettype none
`include "flux_pll_bit_decoder_defines.svh"

module flux_pll_bit_decoder (
  input  wire                             clk,
  input  wire                             rst,
  fpbd_flux_if.sink                       flux_in,
  fpbd_byte_if.source                     byte_out,
  input  wire                             cfg_we,
  input  wire [fpbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [fpbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpbd_pkg::*;

  // configuration
  logic [CELL_W-1:0]  cell_cfg;
  logic [GAIN_W-1:0]  gain_cfg;
  logic [LIMIT_W-1:0] limit_cfg;

  // architectural state
  logic [PHASE_W-1:0] phase_acc;
  logic [BYTE_W-1:0]  shift_byte;
  logic [2:0]         bit_counter;
  logic [INDEX_W-1:0] byte_counter;

  // sequencer and working registers
  fpbd_state_t         state, state_next;
  logic [1:0]          k;
  logic [INTERVAL_W-1:0] interval_r;
  logic signed [26:0]  num2;
  logic [22:0]         m;
  logic [2:0]          cells;
  logic signed [25:0]  err;
  logic signed [37:0]  prod;
  logic [2:0]          rem;

  // output register
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [INDEX_W-1:0] byte_index_r;

  // combinational
  logic               in_ready;
  logic               accept;
  logic               limit_hit;
  logic [CELL_W-1:0]  cell_eff;
  logic [PHASE_W-1:0] phase_eff;
  logic [INDEX_W-1:0] bytecnt_eff;
  logic [25:0]        num_w;
  logic [22:0]        m_sum;
  logic [21:0]        cc;
  logic signed [38:0] prod_w;
  logic signed [37:0] psum;
  logic signed [PHASE_W+1:0] phase_sum;
  logic               out_free;
  logic               wrap;
  logic               bit_go;
  logic               emit;
  logic [BYTE_W-1:0]  sb_new;

  assign cell_eff    = (cell_cfg == '0) ? CELL_W'(1) : cell_cfg;
  assign accept      = flux_in.valid && in_ready;
  assign phase_eff   = flux_in.track_start ? '0 : phase_acc;
  assign bytecnt_eff = flux_in.track_start ? '0 : byte_counter;
  assign limit_hit   = bytecnt_eff >= limit_cfg;

  // interval*256 + phase, both sides extended to 26 bits
  assign num_w = {2'b00, flux_in.flux_interval, 8'h00} + {{2{phase_eff[PHASE_W-1]}}, phase_eff};

  // shared add/compare: next odd multiple of the cell
  assign m_sum = m + {2'b00, cell_eff, 1'b0};

  always_comb begin
    unique case (cells)
      3'd2:    cc = {1'b0, cell_eff, 1'b0};
      3'd3:    cc = {1'b0, cell_eff, 1'b0} + {2'b00, cell_eff};
      3'd4:    cc = {cell_eff, 2'b00};
      default: cc = {2'b00, cell_eff};
    endcase
  end

  assign prod_w    = err * $signed({1'b0, gain_cfg});
  assign psum      = prod + 38'sd2048;
  // floor((prod + 2048) / 4096) is the upper bits of psum; two guard bits
  // keep the sum clear of wrap before saturation
  assign phase_sum = $signed({{2{phase_acc[PHASE_W-1]}}, phase_acc})
                   + $signed(psum[37:12]);

  assign out_free = !out_valid || byte_out.ready;
  assign wrap     = bit_counter == 3'd7;
  assign sb_new   = {shift_byte[BYTE_W-2:0], (rem == 3'd1)};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && !limit_hit) state_next = ST_CMP;
      ST_CMP:  if (k == 2'd2) state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_BITS;
      ST_BITS: if (bit_go && rem == 3'd1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    bit_go   = 1'b0;
    emit     = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_BITS: begin
        bit_go = !wrap || out_free;
        emit   = wrap && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_cfg  <= CELL_RESET;
      gain_cfg  <= GAIN_RESET;
      limit_cfg <= LIMIT_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_CELL:  cell_cfg  <= cfg_data;
        REG_GAIN:  gain_cfg  <= cfg_data[GAIN_W-1:0];
        REG_LIMIT: limit_cfg <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      shift_byte   <= '0;
      bit_counter  <= '0;
      byte_counter <= '0;
    end else begin
      if (accept && flux_in.track_start) begin
        phase_acc    <= '0;
        shift_byte   <= '0;
        bit_counter  <= '0;
        byte_counter <= '0;
      end
      if (state == ST_UPD) begin
        if (phase_sum > PHASE_MAX)      phase_acc <= PHASE_MAX[PHASE_W-1:0];
        else if (phase_sum < PHASE_MIN) phase_acc <= PHASE_MIN[PHASE_W-1:0];
        else                            phase_acc <= phase_sum[PHASE_W-1:0];
      end
      if (bit_go) begin
        bit_counter <= bit_counter + 3'd1;
        if (wrap) begin
          shift_byte   <= '0;
          byte_counter <= byte_counter + INDEX_W'(1);
        end else begin
          shift_byte   <= sb_new;
        end
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        interval_r <= flux_in.flux_interval;
        num2       <= {num_w, 1'b0};
        m          <= {3'b000, cell_eff};
        cells      <= 3'd1;
        k          <= 2'd0;
      end
      ST_CMP: begin
        // count of odd half-cell multiples that num reaches (2*num against odd cell multiples)
        m <= m_sum;
        k <= k + 2'd1;
        if (num2 >= $signed({4'b0000, m_sum})) cells <= cells + 3'd1;
      end
      ST_ERR:  err  <= $signed({2'b00, interval_r, 8'h00}) - $signed({4'b0000, cc});
      ST_MUL:  prod <= prod_w[37:0];
      ST_UPD:  rem  <= cells;
      ST_BITS: if (bit_go) rem <= rem - 3'd1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (byte_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r   <= sb_new;
      byte_index_r <= byte_counter;
    end
  end

  assign flux_in.ready       = in_ready;
  assign byte_out.valid      = out_valid;
  assign byte_out.out_byte   = out_byte_r;
  assign byte_out.byte_index = byte_index_r;

  `FPBD_ASSERT_IMPLIES(a_bits_left, clk, rst, state == ST_BITS, rem != 3'd0, "bit stage with no bits left")
  `FPBD_ASSERT_IMPLIES(a_cells_range, clk, rst, state == ST_ERR, cells >= 3'd1 && cells <= 3'd4, "cell count out of range")
  `FPBD_ASSERT_NEXT(a_index_step, clk, rst, emit, byte_counter == 16'($past(byte_counter) + 16'd1) && byte_out.valid, "byte index did not advance")

endmodule

`default_nettype wire

### test/flux_pll_bit_decoder_tb.sv
// Testbench for flux_pll_bit_decoder: drives flux intervals, predicts decoded bytes
// with its own PLL and bit-packing model, and checks every byte word in order.
// Depends on fpbd_pkg, fpbd_flux_if, fpbd_byte_if and the decoder RTL.
`timescale 1ns / 1ps

module flux_pll_bit_decoder_tb;
  import fpbd_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int MAX_PRINTS    = 60;

  typedef struct {
    logic [BYTE_W-1:0]  value;
    logic [INDEX_W-1:0] index;
  } byte_word_t;

  // Decoder state mirror plus the queue of bytes still owed by the block.
  class byte_ledger;
    logic [CELL_W-1:0]         cell_q8;
    logic [GAIN_W-1:0]         gain_q12;
    logic [LIMIT_W-1:0]        limit;
    logic signed [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]         shreg;
    logic [2:0]                nbits;
    logic [INDEX_W-1:0]        count;
    byte_word_t                due_bytes[$];
    int                        used_count;
    int                        errors;

    function void clear();
      cell_q8  = CELL_RESET;
      gain_q12 = GAIN_RESET;
      limit    = LIMIT_RESET;
      phase    = '0;
      shreg    = '0;
      nbits    = '0;
      count    = '0;
      due_bytes.delete();
      used_count = 0;
      errors     = 0;
    endfunction

    // One accepted interval word: cell rounding, phase update, bit packing.
    function void take_interval(logic [INTERVAL_W-1:0] iv, logic st);
      longint     c, ph, num, cells, err, step;
      byte_word_t w;
      if (st) begin
        phase = '0;
        shreg = '0;
        nbits = '0;
        count = '0;
      end
      if (count >= limit) return;
      used_count++;
      c = (cell_q8 == 0) ? 64'sd1 : longint'(cell_q8);
      ph = phase;
      num = longint'(iv) * 256 + ph;
      if (num < 0) begin
        cells = 1;
      end else begin
        cells = (2 * num + c) / (2 * c);
        if (cells < 1) cells = 1;
        if (cells > 4) cells = 4;
      end
      err = longint'(iv) * 256 - cells * c;
      // arithmetic shift gives floor, so halves round up
      step = (err * longint'(gain_q12) + 2048) >>> 12;
      ph = ph + step;
      if (ph > longint'(PHASE_MAX)) ph = longint'(PHASE_MAX);
      if (ph < longint'(PHASE_MIN)) ph = longint'(PHASE_MIN);
      phase = ph[PHASE_W-1:0];
      for (int k = 0; k < cells; k++) begin
        shreg = {shreg[BYTE_W-2:0], (k == cells - 1)};
        nbits = nbits + 3'd1;
        if (nbits == 0) begin
          w.value = shreg;
          w.index = count;
          due_bytes.push_back(w);
          count = count + 1'b1;
          shreg = '0;
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", what);
    endtask

    task match_byte(logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] idx);
      byte_word_t w;
      if (due_bytes.size() == 0) begin
        report($sformatf("byte %02h index %0d arrived with none expected", b, idx));
        return;
      end
      w = due_bytes.pop_front();
      if (b !== w.value)
        report($sformatf("out_byte %02h, expected %02h (index %0d)", b, w.value, w.index));
      if (idx !== w.index)
        report($sformatf("byte_index %0d, expected %0d", idx, w.index));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm;
  byte_ledger            ledger;

  fpbd_flux_if flux_ch();
  fpbd_byte_if byte_ch();

  flux_pll_bit_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .flux_in   (flux_ch),
    .byte_out  (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("flux_pll_bit_decoder_tb: done, errors");
    $finish;
  end

  // Byte sink stalls at random except in the calm phase.
  initial begin
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      byte_ch.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
      ledger.match_byte(byte_ch.out_byte, byte_ch.byte_index);
  end

  // valid is left high after a word is taken; the next call or settle() decides.
  task automatic send_interval(input logic [INTERVAL_W-1:0] iv, input logic st);
    int gap;
    gap = (!calm && $urandom_range(99) < 12) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      flux_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    flux_ch.valid         <= 1'b1;
    flux_ch.flux_interval <= iv;
    flux_ch.track_start   <= st;
    @(posedge clk);
    while (flux_ch.ready !== 1'b1) @(posedge clk);
    ledger.take_interval(iv, st);
  endtask

  // Wait for every owed byte, then give ignored or trailing intervals time to finish.
  task automatic settle();
    flux_ch.valid <= 1'b0;
    while (ledger.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic [CELL_W-1:0] cell_len, input logic [GAIN_W-1:0] gain,
                           input logic [LIMIT_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CELL;
    cfg_data  <= CFG_DATA_W'(cell_len);
    @(posedge clk);
    cfg_index <= REG_GAIN;
    cfg_data  <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.cell_q8  = cell_len;
    ledger.gain_q12 = gain;
    ledger.limit    = lim;
  endtask

  // Mostly 1..4 cells with jitter; some raw noise and some extreme intervals.
  function automatic logic [INTERVAL_W-1:0] pick_interval(logic [CELL_W-1:0] cell_len);
    int unsigned roll, span, base;
    roll = $urandom_range(99);
    if (roll < 8) return INTERVAL_W'($urandom_range(0, 65535));
    if (roll < 11) return roll[0] ? 16'hFFFF : 16'h0000;
    span = ((cell_len >> 8) == 0) ? 1 : (cell_len >> 8);
    base = $urandom_range(1, 4) * span + $urandom_range(0, span / 2) - span / 4;
    return (base > 65535) ? 16'hFFFF : INTERVAL_W'(base);
  endfunction

  initial begin
    logic [CELL_W-1:0]  cell_len;
    logic [GAIN_W-1:0]  gain;
    logic [LIMIT_W-1:0] lim;
    int                 restart_pct;
    int                 goal;
    logic               st;
    ledger = new();
    ledger.clear();
    calm = 1'b0;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_CELL;
    cfg_data              <= '0;
    flux_ch.valid         <= 1'b0;
    flux_ch.flux_interval <= '0;
    flux_ch.track_start   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: shortest and longest interval, then 1..4 cells
    send_interval(16'd0, 1'b1);
    send_interval(16'hFFFF, 1'b0);
    send_interval(16'd48, 1'b0);
    send_interval(16'd96, 1'b0);
    send_interval(16'd144, 1'b0);
    send_interval(16'd192, 1'b0);
    settle();

    // zero cell length acts as one; full gain drives phase to the positive bound
    load_regs(20'd0, 12'd4095, 16'hFFFF);
    send_interval(16'hFFFF, 1'b1);
    send_interval(16'hFFFF, 1'b0);
    settle();

    // longest cell, zero intervals: phase walks to the negative bound
    load_regs(20'hFFFFF, 12'd4095, 16'hFFFF);
    send_interval(16'd0, 1'b1);
    repeat (9) send_interval(16'd0, 1'b0);
    settle();

    // zero limit: everything ignored
    load_regs(CELL_RESET, GAIN_RESET, 16'd0);
    send_interval(16'd48, 1'b1);
    send_interval(16'd96, 1'b0);
    settle();

    // limit of one byte, then a track start reopens the track
    load_regs(CELL_RESET, GAIN_RESET, 16'd1);
    send_interval(16'd192, 1'b1);
    send_interval(16'd192, 1'b0);
    send_interval(16'd192, 1'b0);
    send_interval(16'd48, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      cell_len = (p == 0) ? 20'd256
                          : CELL_W'($urandom_range(4, 160) * 256 + $urandom_range(0, 255));
      gain = (p == 1) ? 12'd0 : (p == 2) ? 12'd4095 : GAIN_W'($urandom_range(0, 4095));
      lim  = (p == 5 || p == 6) ? LIMIT_W'($urandom_range(1, 40)) : 16'hFFFF;
      load_regs(cell_len, gain, lim);
      calm = (p == 4);
      restart_pct = (lim != 16'hFFFF) ? 10 : 2;
      goal = ledger.used_count + PHASE_ITEMS;
      st = 1'b1;
      while (ledger.used_count < goal) begin
        send_interval(pick_interval(cell_len), st);
        st = ($urandom_range(99) < restart_pct);
        // hold the sender until the sink has drained
        if (p == 3 && ledger.used_count == goal - PHASE_ITEMS / 2) settle();
      end
      calm = 1'b0;
      settle();
    end

    if (ledger.errors == 0) begin
      $display("flux_pll_bit_decoder_tb: done, clean");
    end else begin
      $display("flux_pll_bit_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
